FILE: sv/go_back_n_arq_sender_unit_defines.svh
// Assertion macros shared by the Go-Back-N ARQ sender RTL.
`ifndef GO_BACK_N_ARQ_SENDER_UNIT_DEFINES_SVH
`define GO_BACK_N_ARQ_SENDER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// A condition that must hold at every clock edge outside reset.
`define GBN_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);
// An implication checked in the same cycle.
`define GBN_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define GBN_ASSERT(label, cond, msg)
`define GBN_ASSERT_IMPL(label, ante, cons, msg)
`endif

`endif

FILE: sv/gbn_arq_pkg.sv
// Shared types and constants of the Go-Back-N ARQ sender.
`default_nettype none

package gbn_arq_pkg;

  // Fixed field widths of the ports.
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned ACK_W      = 2;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned SEQ_OUT_W  = 2;
  localparam int unsigned CNT_OUT_W  = 2;
  localparam int unsigned WIN_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Most frames resent for one timer expiry.
  localparam int unsigned RESEND_MAX = 3;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_SEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_SENT    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RESENT  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ACK_OK  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ACK_BAD = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REFUSED = 3'd4;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0]  CFG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_TIMEOUT     = 2'd1;
  localparam logic [WIN_W-1:0]      WIN_RESET       = 2'd3;
  localparam logic [CFG_DATA_W-1:0] TIMEOUT_RESET   = 16'd5;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_UPDATE,
    ST_BUMP,
    ST_READ,
    ST_RESEND
  } state_e;

endpackage

`default_nettype wire

FILE: sv/gbn_arq_alu.sv
// Shared add/subtract unit; the carry doubles as the not-less-than flag on subtract.
`default_nettype none

module gbn_arq_alu #(
  parameter int unsigned W = 16
) (
  input  var gbn_arq_pkg::alu_op_e op_i,
  input  var logic [W-1:0]         a_i,
  input  var logic [W-1:0]         b_i,
  output var logic [W-1:0]         sum_o,
  output var logic                 carry_o
);

  logic [W-1:0] b_eff;
  logic         cin;
  logic [W:0]   total;

  // Subtraction is a plus the one's complement of b plus one.
  assign cin   = (op_i == gbn_arq_pkg::ALU_SUB);
  assign b_eff = cin ? ~b_i : b_i;
  assign total = {1'b0, a_i} + {1'b0, b_eff} + {{W{1'b0}}, cin};

  assign sum_o   = total[W-1:0];
  assign carry_o = total[W];

endmodule

`default_nettype wire

FILE: sv/gbn_arq_frame_store.sv
// Frame buffer indexed by sequence number, with a registered read port.
`default_nettype none

module gbn_arq_frame_store #(
  parameter int unsigned ADDR_W = 2,
  parameter int unsigned DATA_W = 16
) (
  input  var logic              clk_i,
  input  var logic              wr_en_i,
  input  var logic [ADDR_W-1:0] wr_addr_i,
  input  var logic [DATA_W-1:0] wr_data_i,
  input  var logic              rd_en_i,
  input  var logic [ADDR_W-1:0] rd_addr_i,
  output var logic [DATA_W-1:0] rd_data_o
);

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: sv/go_back_n_arq_sender_unit.sv
// Top level of the Go-Back-N ARQ sender: sequencer, state and output register.
// A send is checked against the window (a refusal is registered from the check), then is
// written to the frame store and counted before its result is registered; an ack is checked
// then applied; an expiring tick reads each frame to resend, then emits it. A new transaction
// waits until the last is done; the shared adder, single frame store read port and stalls pace them.
// Asynchronous reset empties the window, stops the timer and restores both registers.
`default_nettype none

`include "go_back_n_arq_sender_unit_defines.svh"

module go_back_n_arq_sender_unit #(
  parameter int unsigned SEQ_BITS    = 2,
  parameter int unsigned DATA_WIDTH  = 16,
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  var logic                                  clk_i,
  input  var logic                                  rst_ni,
  // Input transactions.
  input  var logic                                  in_valid_i,
  output var logic                                  in_ready_o,
  input  var logic [gbn_arq_pkg::CMD_W-1:0]         command_i,
  input  var logic [DATA_WIDTH-1:0]                 payload_i,
  input  var logic [gbn_arq_pkg::ACK_W-1:0]         ack_number_i,
  // Result transactions.
  output var logic                                  out_valid_o,
  input  var logic                                  out_ready_i,
  output var logic [gbn_arq_pkg::KIND_W-1:0]        kind_o,
  output var logic [gbn_arq_pkg::SEQ_OUT_W-1:0]     seq_number_o,
  output var logic [DATA_WIDTH-1:0]                 frame_data_o,
  output var logic [gbn_arq_pkg::CNT_OUT_W-1:0]     outstanding_o,
  output var logic                                  last_o,
  // Configuration writes.
  input  var logic                                  cfg_valid_i,
  output var logic                                  cfg_ready_o,
  input  var logic [gbn_arq_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  var logic [gbn_arq_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  // The shared unit must hold a timer count, a timeout value and a sequence
  // number with one spare bit.
  localparam int unsigned UW0 = (TIMER_WIDTH > gbn_arq_pkg::CFG_DATA_W) ?
                                TIMER_WIDTH : gbn_arq_pkg::CFG_DATA_W;
  localparam int unsigned UW  = (UW0 > SEQ_BITS) ? UW0 : SEQ_BITS + 1;

  localparam logic [SEQ_BITS-1:0]    SEQ_MAX   = '1;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

  // Control state.
  gbn_arq_pkg::state_e state_q, state_d;
  logic [SEQ_BITS-1:0]    base_q, base_d;
  logic [SEQ_BITS-1:0]    next_seq_q, next_seq_d;
  logic [SEQ_BITS-1:0]    in_flight_q, in_flight_d;
  logic [TIMER_WIDTH-1:0] timer_q, timer_d;
  logic                   running_q, running_d;
  logic [SEQ_BITS-1:0]    scratch_q, scratch_d;
  logic [1:0]             idx_q, idx_d;

  // Configuration registers.
  logic [gbn_arq_pkg::WIN_W-1:0]      window_size_q;
  logic [gbn_arq_pkg::CFG_DATA_W-1:0] timeout_q;

  // Captured input transaction.
  logic [gbn_arq_pkg::CMD_W-1:0] cmd_q;
  logic [DATA_WIDTH-1:0]         payload_q;
  logic [SEQ_BITS-1:0]           ack_q;

  // Output register.
  logic                                 out_valid_q;
  logic [gbn_arq_pkg::KIND_W-1:0]       kind_q;
  logic [gbn_arq_pkg::SEQ_OUT_W-1:0]    seq_q;
  logic [DATA_WIDTH-1:0]                data_q;
  logic [gbn_arq_pkg::CNT_OUT_W-1:0]    outst_q;
  logic                                 last_q;

  // Shared unit.
  gbn_arq_pkg::alu_op_e alu_op;
  logic [UW-1:0]        alu_a;
  logic [UW-1:0]        alu_b;
  logic [UW-1:0]        alu_sum;
  logic                 alu_carry;
  logic                 alu_lt;

  // Result produced by the sequencer this cycle.
  logic                           emit;
  logic [gbn_arq_pkg::KIND_W-1:0] emit_kind;
  logic [SEQ_BITS-1:0]            emit_seq;
  logic [DATA_WIDTH-1:0]          emit_data;
  logic [SEQ_BITS-1:0]            emit_outst;
  logic                           emit_last;

  // Frame store ports.
  logic                  mem_wr_en;
  logic                  mem_rd_en;
  logic [SEQ_BITS-1:0]   mem_rd_addr;
  logic [DATA_WIDTH-1:0] mem_rd_data;

  logic                in_fire;
  logic                cfg_fire;
  logic                out_free;
  logic                advance;
  logic [SEQ_BITS-1:0] win;
  logic                ack_valid;
  logic                burst_last;
  logic                burst_done;

  assign in_ready_o  = (state_q == gbn_arq_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // A result can be loaded when the output register is empty or is being
  // drained this cycle; otherwise the sequencer holds where it is.
  assign out_free = !out_valid_q || out_ready_i;
  assign advance  = !emit || out_free;

  // The effective window is capped at one less than the sequence space.
  always_comb begin
    if (UW'(window_size_q) > UW'(SEQ_MAX)) begin
      win = SEQ_MAX;
    end else begin
      win = SEQ_BITS'(UW'(window_size_q));
    end
  end

  // On subtract, a clear carry means a is below b.
  assign alu_lt = !alu_carry;

  // An ack is in range when its offset from the base is nonzero and no
  // larger than the number of frames outstanding.
  assign ack_valid = (scratch_q != '0) && !alu_lt;

  // A resend burst ends on the last outstanding frame or at the burst cap.
  assign burst_last = ((UW'(idx_q) + UW'(1)) == UW'(in_flight_q));
  assign burst_done = burst_last || (idx_q == 2'(gbn_arq_pkg::RESEND_MAX - 1));

  gbn_arq_alu #(
    .W (UW)
  ) u_alu (
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sum_o   (alu_sum),
    .carry_o (alu_carry)
  );

  gbn_arq_frame_store #(
    .ADDR_W (SEQ_BITS),
    .DATA_W (DATA_WIDTH)
  ) u_frame_store (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (next_seq_q),
    .wr_data_i (payload_q),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      gbn_arq_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = gbn_arq_pkg::ST_CHECK;
        end
      end
      gbn_arq_pkg::ST_CHECK: begin
        case (cmd_q)
          gbn_arq_pkg::CMD_SEND: begin
            state_d = alu_lt ? gbn_arq_pkg::ST_UPDATE : gbn_arq_pkg::ST_IDLE;
          end
          gbn_arq_pkg::CMD_ACK: begin
            state_d = gbn_arq_pkg::ST_UPDATE;
          end
          gbn_arq_pkg::CMD_TICK: begin
            state_d = running_q ? gbn_arq_pkg::ST_UPDATE : gbn_arq_pkg::ST_IDLE;
          end
          default: begin
            state_d = gbn_arq_pkg::ST_IDLE;
          end
        endcase
      end
      gbn_arq_pkg::ST_UPDATE: begin
        if (cmd_q == gbn_arq_pkg::CMD_SEND) begin
          state_d = gbn_arq_pkg::ST_BUMP;
        end else if (cmd_q == gbn_arq_pkg::CMD_TICK && !alu_lt && in_flight_q != '0) begin
          state_d = gbn_arq_pkg::ST_READ;
        end else begin
          state_d = gbn_arq_pkg::ST_IDLE;
        end
      end
      gbn_arq_pkg::ST_BUMP: begin
        state_d = gbn_arq_pkg::ST_IDLE;
      end
      gbn_arq_pkg::ST_READ: begin
        state_d = gbn_arq_pkg::ST_RESEND;
      end
      gbn_arq_pkg::ST_RESEND: begin
        state_d = burst_done ? gbn_arq_pkg::ST_IDLE : gbn_arq_pkg::ST_READ;
      end
      default: begin
        state_d = gbn_arq_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath controls, state updates and the result of each step.
  always_comb begin
    alu_op      = gbn_arq_pkg::ALU_ADD;
    alu_a       = '0;
    alu_b       = '0;
    emit        = 1'b0;
    emit_kind   = gbn_arq_pkg::KIND_SENT;
    emit_seq    = '0;
    emit_data   = '0;
    emit_outst  = in_flight_q;
    emit_last   = 1'b1;
    mem_wr_en   = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    base_d      = base_q;
    next_seq_d  = next_seq_q;
    in_flight_d = in_flight_q;
    timer_d     = timer_q;
    running_d   = running_q;
    scratch_d   = scratch_q;
    idx_d       = idx_q;
    case (state_q)
      gbn_arq_pkg::ST_CHECK: begin
        case (cmd_q)
          gbn_arq_pkg::CMD_SEND: begin
            // Window check: refuse when in_flight has reached the window.
            alu_op = gbn_arq_pkg::ALU_SUB;
            alu_a  = UW'(in_flight_q);
            alu_b  = UW'(win);
            if (!alu_lt) begin
              emit      = 1'b1;
              emit_kind = gbn_arq_pkg::KIND_REFUSED;
              emit_seq  = next_seq_q;
            end
          end
          gbn_arq_pkg::CMD_ACK: begin
            // Offset of the ack from the base, modulo the sequence space.
            alu_op    = gbn_arq_pkg::ALU_SUB;
            alu_a     = UW'(ack_q);
            alu_b     = UW'(base_q);
            scratch_d = alu_sum[SEQ_BITS-1:0];
          end
          gbn_arq_pkg::CMD_TICK: begin
            // Saturating timer increment.
            alu_a = UW'(timer_q);
            alu_b = UW'(1);
            if (running_q && timer_q != TIMER_MAX) begin
              timer_d = alu_sum[TIMER_WIDTH-1:0];
            end
          end
          default: begin
            alu_op = gbn_arq_pkg::ALU_ADD;
          end
        endcase
      end
      gbn_arq_pkg::ST_UPDATE: begin
        case (cmd_q)
          gbn_arq_pkg::CMD_SEND: begin
            mem_wr_en  = 1'b1;
            alu_a      = UW'(next_seq_q);
            alu_b      = UW'(1);
            next_seq_d = alu_sum[SEQ_BITS-1:0];
            scratch_d  = next_seq_q;
          end
          gbn_arq_pkg::CMD_ACK: begin
            alu_op    = gbn_arq_pkg::ALU_SUB;
            alu_a     = UW'(in_flight_q);
            alu_b     = UW'(scratch_q);
            emit      = 1'b1;
            if (ack_valid) begin
              base_d      = ack_q;
              in_flight_d = alu_sum[SEQ_BITS-1:0];
              timer_d     = '0;
              running_d   = (alu_sum[SEQ_BITS-1:0] != '0);
              emit_kind   = gbn_arq_pkg::KIND_ACK_OK;
              emit_seq    = ack_q;
              emit_outst  = alu_sum[SEQ_BITS-1:0];
            end else begin
              emit_kind = gbn_arq_pkg::KIND_ACK_BAD;
              emit_seq  = base_q;
            end
          end
          gbn_arq_pkg::CMD_TICK: begin
            // Expiry when the count has reached the timeout.
            alu_op = gbn_arq_pkg::ALU_SUB;
            alu_a  = UW'(timer_q);
            alu_b  = UW'(timeout_q);
            if (!alu_lt) begin
              timer_d = '0;
              idx_d   = '0;
              if (in_flight_q == '0) begin
                running_d = 1'b0;
              end
            end
          end
          default: begin
            alu_op = gbn_arq_pkg::ALU_ADD;
          end
        endcase
      end
      gbn_arq_pkg::ST_BUMP: begin
        alu_a       = UW'(in_flight_q);
        alu_b       = UW'(1);
        in_flight_d = alu_sum[SEQ_BITS-1:0];
        if (!running_q) begin
          running_d = 1'b1;
          timer_d   = '0;
        end
        emit       = 1'b1;
        emit_kind  = gbn_arq_pkg::KIND_SENT;
        emit_seq   = scratch_q;
        emit_data  = payload_q;
        emit_outst = alu_sum[SEQ_BITS-1:0];
      end
      gbn_arq_pkg::ST_READ: begin
        // Slot of the next frame to resend, modulo the sequence space.
        alu_a       = UW'(base_q);
        alu_b       = UW'(idx_q);
        mem_rd_en   = 1'b1;
        mem_rd_addr = alu_sum[SEQ_BITS-1:0];
        scratch_d   = alu_sum[SEQ_BITS-1:0];
      end
      gbn_arq_pkg::ST_RESEND: begin
        emit      = 1'b1;
        emit_kind = gbn_arq_pkg::KIND_RESENT;
        emit_seq  = scratch_q;
        emit_data = mem_rd_data;
        emit_last = burst_last;
        idx_d     = idx_q + 2'd1;
      end
      default: begin
        alu_op = gbn_arq_pkg::ALU_ADD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gbn_arq_pkg::ST_IDLE;
      base_q      <= '0;
      next_seq_q  <= '0;
      in_flight_q <= '0;
      timer_q     <= '0;
      running_q   <= 1'b0;
      scratch_q   <= '0;
      idx_q       <= '0;
    end else if (advance) begin
      state_q     <= state_d;
      base_q      <= base_d;
      next_seq_q  <= next_seq_d;
      in_flight_q <= in_flight_d;
      timer_q     <= timer_d;
      running_q   <= running_d;
      scratch_q   <= scratch_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= gbn_arq_pkg::WIN_RESET;
      timeout_q     <= gbn_arq_pkg::TIMEOUT_RESET;
    end else if (cfg_fire) begin
      case (cfg_index_i)
        gbn_arq_pkg::CFG_WINDOW_SIZE: begin
          window_size_q <= cfg_data_i[gbn_arq_pkg::WIN_W-1:0];
        end
        gbn_arq_pkg::CFG_TIMEOUT: begin
          timeout_q <= cfg_data_i;
        end
        default: begin
          timeout_q <= timeout_q;
        end
      endcase
    end
  end

  // The input transaction is held for the whole of its sequence.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q     <= command_i;
      payload_q <= payload_i;
      ack_q     <= SEQ_BITS'(UW'(ack_number_i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit && out_free) begin
      kind_q  <= emit_kind;
      seq_q   <= gbn_arq_pkg::SEQ_OUT_W'(UW'(emit_seq));
      data_q  <= emit_data;
      outst_q <= gbn_arq_pkg::CNT_OUT_W'(UW'(emit_outst));
      last_q  <= emit_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign seq_number_o  = seq_q;
  assign frame_data_o  = data_q;
  assign outstanding_o = outst_q;
  assign last_o        = last_q;

  // Between transactions the outstanding count matches the distance from
  // the window base to the next sequence number.
  `GBN_ASSERT_IMPL(a_window_consistent, state_q == gbn_arq_pkg::ST_IDLE, SEQ_BITS'(next_seq_q - base_q) == in_flight_q, "in_flight disagrees with next_seq - base")

  // Frames in flight always have the retransmit timer running.
  `GBN_ASSERT_IMPL(a_timer_runs, state_q == gbn_arq_pkg::ST_IDLE && in_flight_q != '0, running_q, "frames outstanding with the timer stopped")

  // A resend burst never goes past its cap.
  `GBN_ASSERT(a_burst_cap, state_q != gbn_arq_pkg::ST_RESEND || idx_q != 2'd3, "resend index beyond the burst cap")

endmodule

`default_nettype wire
